FILE: src/bep_pkg.sv
`default_nettype none
package bep_pkg;

    localparam int COORD_W   = 32;
    localparam int COEF_W    = 40;
    localparam int NORM_BITS = 30;
    localparam int NORM_W    = NORM_BITS + 1;
    localparam int PROD_W    = 2 * NORM_W;
    localparam int DISC_W    = 64;
    localparam int ROOT_W    = 32;
    localparam int TFRAC     = 30;
    localparam int T_W       = TFRAC + 1;
    localparam int PT_W      = COORD_W + 2;
    localparam int LPROD_W   = PT_W + T_W + 1;
    localparam int MAX_ROOTS = 4;
    localparam int LERP_N    = 6;
    localparam int THR_W     = 16;
    localparam int IN_DATA_W = 8 * COORD_W;
    localparam int OUT_DATA_W = 2 * COORD_W;

    localparam logic [1:0] KIND_LINE      = 2'd0;
    localparam logic [1:0] KIND_CUBIC     = 2'd2;
    localparam logic [1:0] KIND_CUBIC_ALT = 2'd3;

    typedef enum logic [1:0] {
        SRC_START = 2'd0,
        SRC_END   = 2'd1,
        SRC_XEXT  = 2'd2,
        SRC_YEXT  = 2'd3
    } src_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
    } coef_t;

    typedef struct packed {
        logic                     line;
        logic                     cubic;
        logic [3:0][COORD_W-1:0]  px;
        logic [3:0][COORD_W-1:0]  py;
        coef_t                    cx;
        coef_t                    cy;
    } item_t;

    typedef struct packed {
        logic done;
        logic ok;
    } div_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COEF,
        ST_MULT,
        ST_DISC,
        ST_SQRT,
        ST_QUOT,
        ST_DIV1,
        ST_DIV2,
        ST_DIV_ONE,
        ST_EMIT,
        ST_EVAL_MUL,
        ST_EVAL_ADD,
        ST_PUSH
    } back_state_t;

    function automatic logic [COEF_W-1:0] coef_mag(input logic signed [COEF_W-1:0] v);
        coef_mag = v[COEF_W-1] ? $unsigned(-v) : $unsigned(v);
    endfunction

endpackage
`default_nettype wire

FILE: src/bep_front.sv
`default_nettype none
module bep_front
    import bep_pkg::*;
(
    input  wire logic [IN_DATA_W-1:0] s_axis_tdata,
    input  wire logic [1:0]           s_axis_tuser,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic                 q_full,
    output logic                      q_push,
    output item_t                     q_item
);

    // Derivative coefficients from the points raised to cubic form and scaled by 3.
    function automatic coef_t axis_coefs(input logic [3:0][COORD_W-1:0] p, input logic cubic);
        logic signed [COEF_W-1:0] e0, e1, e2, e3, s0, s1, s2, s3, d12;
        coef_t r;
        e0 = COEF_W'($signed(p[0]));
        e1 = COEF_W'($signed(p[1]));
        e2 = COEF_W'($signed(p[2]));
        e3 = COEF_W'($signed(p[3]));
        s0 = (e0 <<< 1) + e0;
        s3 = (e3 <<< 1) + e3;
        if (cubic)
        begin
            s1 = (e1 <<< 1) + e1;
            s2 = (e2 <<< 1) + e2;
        end
        else
        begin
            s1 = e0 + (e1 <<< 1);
            s2 = (e1 <<< 1) + e3;
        end
        d12 = s1 - s2;
        r.a = s3 - s0 + (d12 <<< 1) + d12;
        r.b = (s0 - (s1 <<< 1) + s2) <<< 1;
        r.c = s1 - s0;
        axis_coefs = r;
    endfunction

    logic                    cubic;
    logic [3:0][COORD_W-1:0] px;
    logic [3:0][COORD_W-1:0] py;

    always_comb
    begin
        // Kind three is handled as a cubic.
        cubic = (s_axis_tuser == KIND_CUBIC) || (s_axis_tuser == KIND_CUBIC_ALT);
        px[0] = s_axis_tdata[0*COORD_W +: COORD_W];
        py[0] = s_axis_tdata[1*COORD_W +: COORD_W];
        px[1] = s_axis_tdata[2*COORD_W +: COORD_W];
        py[1] = s_axis_tdata[3*COORD_W +: COORD_W];
        px[2] = s_axis_tdata[4*COORD_W +: COORD_W];
        py[2] = s_axis_tdata[5*COORD_W +: COORD_W];
        px[3] = s_axis_tdata[6*COORD_W +: COORD_W];
        py[3] = s_axis_tdata[7*COORD_W +: COORD_W];
        q_item.line  = (s_axis_tuser == KIND_LINE);
        q_item.cubic = cubic;
        q_item.px    = px;
        q_item.py    = py;
        q_item.cx    = axis_coefs(px, cubic);
        q_item.cy    = axis_coefs(py, cubic);
        s_axis_tready = !q_full;
        q_push = s_axis_tvalid && !q_full;
    end

endmodule
`default_nettype wire

FILE: src/bep_queue.sv
`default_nettype none
module bep_queue
    import bep_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t push_item,
    output logic       full,
    input  wire logic  pop,
    output item_t      head,
    output logic       valid
);

    item_t      mem_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb
    begin
        full  = (count_reg == 2'd2);
        valid = (count_reg != 2'd0);
        head  = mem_reg[rptr_reg];
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wptr_reg <= !wptr_reg;
            if (pop)
                rptr_reg <= !rptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= push_item;
    end

endmodule
`default_nettype wire

FILE: src/bep_isqrt.sv
`default_nettype none
module bep_isqrt
    import bep_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DISC_W-1:0] value,
    output logic                   done,
    output logic [ROOT_W-1:0]      root
);

    logic              busy_reg;
    logic              done_reg;
    logic [DISC_W-1:0] v_reg;
    logic [DISC_W-1:0] r_reg;
    logic [DISC_W-1:0] bit_reg;
    logic [DISC_W-1:0] trial;
    logic              take;

    // Two result bits per pass would be faster; one pass settles one bit pair here.
    always_comb
    begin
        trial = r_reg + bit_reg;
        take  = (v_reg >= trial);
        done  = done_reg;
        root  = r_reg[ROOT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                busy_reg <= 1'b1;
            else if (busy_reg && bit_reg[0])
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= value;
            r_reg   <= '0;
            bit_reg <= DISC_W'(1) << (DISC_W - 2);
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                v_reg <= v_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
                r_reg <= r_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
    end

endmodule
`default_nettype wire

FILE: src/bep_div.sv
`default_nettype none
module bep_div
    import bep_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic signed [COEF_W-1:0] num,
    input  wire logic signed [COEF_W-1:0] den,
    output div_status_t                   status,
    output logic [T_W-1:0]                quot
);

    logic              busy_reg;
    logic              done_reg;
    logic              ok_reg;
    logic [4:0]        cnt_reg;
    logic [COEF_W:0]   rem_reg;
    logic [COEF_W-1:0] ud_reg;
    logic [T_W-1:0]    q_reg;
    logic [COEF_W-1:0] un;
    logic [COEF_W-1:0] ud;
    logic              reject;
    logic [COEF_W:0]   rr;
    logic              ge;

    always_comb
    begin
        un = coef_mag(num);
        ud = coef_mag(den);
        // A zero divisor, a negative ratio or a ratio above one gives no parameter.
        reject = (den == '0) || ((num != '0) && (num[COEF_W-1] != den[COEF_W-1])) || (un > ud);
        rr = (cnt_reg == 5'd0) ? rem_reg : (rem_reg << 1);
        ge = (rr >= {1'b0, ud_reg});
        status.done = done_reg;
        status.ok   = ok_reg;
        quot = q_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ok_reg   <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= 5'd0;
                if (reject)
                begin
                    done_reg <= 1'b1;
                    ok_reg   <= 1'b0;
                end
                else
                    busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(TFRAC))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    ok_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, un};
            ud_reg  <= ud;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (rr - {1'b0, ud_reg}) : rr;
            q_reg   <= {q_reg[T_W-2:0], ge};
        end
    end

endmodule
`default_nettype wire

FILE: src/bep_back.sv
`default_nettype none
module bep_back
    import bep_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [THR_W-1:0]      threshold,
    input  wire logic                  q_valid,
    input  wire item_t                 q_item,
    output logic                       q_pop,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic [1:0]                 m_axis_tuser,
    output logic                       m_axis_tlast,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready
);

    function automatic logic [COORD_W-1:0] sat_coord(input logic signed [PT_W-1:0] v);
        if (v[PT_W-1:COORD_W-1] == '0 || v[PT_W-1:COORD_W-1] == '1)
            sat_coord = v[COORD_W-1:0];
        else
            sat_coord = v[PT_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    endfunction

    function automatic logic signed [PT_W-1:0] ext_pt(input logic [COORD_W-1:0] v);
        ext_pt = {{(PT_W-COORD_W){v[COORD_W-1]}}, v};
    endfunction

    back_state_t state_reg;
    back_state_t state_next;
    item_t       cur_reg;
    logic        axis_reg;
    logic [2:0]  nroots_reg;
    logic [2:0]  emit_reg;
    logic [2:0]  step_reg;
    logic        ev_axis_reg;

    logic signed [NORM_W-1:0]  a_reg, b_reg, c_reg;
    logic signed [PROD_W-1:0]  bb_reg, ac_reg;
    logic signed [COEF_W-1:0]  q2_reg;
    logic [T_W-1:0]            root_t_reg [MAX_ROOTS];
    logic                      root_src_reg [MAX_ROOTS];
    logic signed [PT_W-1:0]    w_reg [LERP_N];
    logic signed [LPROD_W-1:0] prod_reg;
    logic signed [PT_W-1:0]    lerp_a_reg;
    logic signed [PT_W-1:0]    ptx_reg, pty_reg;

    logic                      out_valid_reg;
    logic [COORD_W-1:0]        out_x_reg, out_y_reg;
    logic [1:0]                out_src_reg;
    logic                      out_last_reg;

    coef_t                     cf;
    logic [COEF_W-1:0]         ma, mb, mc, m_or;
    logic                      a_small, b_small;
    logic [3:0]                sh;
    logic [COEF_W-1:0]         na, nb, nc;
    logic signed [DISC_W-1:0]  disc;
    logic signed [COEF_W-1:0]  sq_ext, b_ext, q2_next;
    logic                      adv_axis, store_root, out_load, out_free, last_flag;
    logic [COORD_W-1:0]        ld_x, ld_y;
    src_t                      ld_src;
    logic [1:0]                ridx;
    logic [2:0]                final_step, step_after;
    logic signed [PT_W-1:0]    la, lb, lerp_res;
    logic [COORD_W-1:0]        pa0, pa1, pa2, pa3;
    logic signed [LPROD_W-1:0] round_sum;

    logic                      div_start, sqrt_start, sqrt_done;
    logic signed [COEF_W-1:0]  div_num, div_den;
    div_status_t               div_st;
    logic [T_W-1:0]            div_q;
    logic [ROOT_W-1:0]         sq_root;

    bep_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value ($unsigned(disc)),
        .done  (sqrt_done),
        .root  (sq_root)
    );

    bep_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .status (div_st),
        .quot   (div_q)
    );

    // Coefficient conditioning for the current axis.
    always_comb
    begin
        cf = axis_reg ? cur_reg.cy : cur_reg.cx;
        ma = coef_mag(cf.a);
        mb = coef_mag(cf.b);
        mc = coef_mag(cf.c);
        a_small = (ma < COEF_W'(threshold));
        b_small = (mb < COEF_W'(threshold));
        m_or = ma | mb | mc;
        sh = 4'd0;
        for (int i = NORM_BITS; i < COEF_W; i++)
        begin
            if (m_or[i])
                sh = 4'(i - NORM_BITS + 1);
        end
        na = ma >> sh;
        nb = mb >> sh;
        nc = mc >> sh;
        disc = DISC_W'(bb_reg) - (DISC_W'(ac_reg) <<< 2);
        sq_ext = $signed({{(COEF_W-ROOT_W){1'b0}}, sq_root});
        b_ext  = COEF_W'(b_reg);
        q2_next = b_reg[NORM_W-1] ? (sq_ext - b_ext) : -(b_ext + sq_ext);
    end

    // Divider operands by phase.
    always_comb
    begin
        case (state_reg)
            ST_COEF:
            begin
                div_num = -cf.c;
                div_den = cf.b;
            end
            ST_QUOT:
            begin
                div_num = q2_reg;
                div_den = COEF_W'(a_reg) <<< 1;
            end
            ST_DIV1:
            begin
                div_num = COEF_W'(c_reg) <<< 1;
                div_den = q2_reg;
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    // Evaluation operands: one lerp per step of the de Casteljau schedule.
    always_comb
    begin
        ridx = 2'(emit_reg - 3'd2);
        pa0 = ev_axis_reg ? cur_reg.py[0] : cur_reg.px[0];
        pa1 = ev_axis_reg ? cur_reg.py[1] : cur_reg.px[1];
        pa2 = ev_axis_reg ? cur_reg.py[2] : cur_reg.px[2];
        pa3 = ev_axis_reg ? cur_reg.py[3] : cur_reg.px[3];
        case (step_reg)
            3'd0:
            begin
                la = ext_pt(pa0);
                lb = ext_pt(pa1);
            end
            3'd1:
            begin
                la = ext_pt(pa1);
                lb = cur_reg.cubic ? ext_pt(pa2) : ext_pt(pa3);
            end
            3'd2:
            begin
                la = ext_pt(pa2);
                lb = ext_pt(pa3);
            end
            3'd3:
            begin
                la = w_reg[0];
                lb = w_reg[1];
            end
            3'd4:
            begin
                la = w_reg[1];
                lb = w_reg[2];
            end
            3'd5:
            begin
                la = w_reg[3];
                lb = w_reg[4];
            end
            default:
            begin
                la = '0;
                lb = '0;
            end
        endcase
        // A quadratic needs three lerps, taken as steps zero, one and three.
        final_step = cur_reg.cubic ? 3'd5 : 3'd3;
        step_after = (!cur_reg.cubic && step_reg == 3'd1) ? 3'd3 : step_reg + 3'd1;
        round_sum = prod_reg + (LPROD_W'(1) <<< (TFRAC - 1));
        lerp_res = lerp_a_reg + PT_W'(round_sum >>> TFRAC);
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        adv_axis   = 1'b0;
        store_root = 1'b0;
        out_load   = 1'b0;
        out_free   = !out_valid_reg || m_axis_tready;
        last_flag  = 1'b0;
        ld_x       = cur_reg.px[0];
        ld_y       = cur_reg.py[0];
        ld_src     = SRC_START;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    state_next = q_item.line ? ST_EMIT : ST_COEF;
                end
            end
            ST_COEF:
            begin
                if (!a_small)
                    state_next = ST_MULT;
                else if (b_small)
                    adv_axis = 1'b1;
                else
                begin
                    div_start = 1'b1;
                    state_next = ST_DIV_ONE;
                end
            end
            ST_MULT:
                state_next = ST_DISC;
            ST_DISC:
            begin
                if (disc[DISC_W-1])
                    adv_axis = 1'b1;
                else
                begin
                    sqrt_start = 1'b1;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (sqrt_done)
                    state_next = ST_QUOT;
            end
            ST_QUOT:
            begin
                div_start = 1'b1;
                state_next = ST_DIV1;
            end
            ST_DIV1:
            begin
                if (div_st.done)
                begin
                    store_root = div_st.ok;
                    div_start = 1'b1;
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2, ST_DIV_ONE:
            begin
                if (div_st.done)
                begin
                    store_root = div_st.ok;
                    adv_axis = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (emit_reg < 3'd2)
                begin
                    if (emit_reg[0])
                    begin
                        ld_x = cur_reg.px[3];
                        ld_y = cur_reg.py[3];
                        ld_src = SRC_END;
                        last_flag = (nroots_reg == 3'd0);
                    end
                    if (out_free)
                    begin
                        out_load = 1'b1;
                        if (last_flag)
                            state_next = ST_IDLE;
                    end
                end
                else
                    state_next = ST_EVAL_MUL;
            end
            ST_EVAL_MUL:
                state_next = ST_EVAL_ADD;
            ST_EVAL_ADD:
            begin
                if (step_reg == final_step && ev_axis_reg)
                    state_next = ST_PUSH;
                else
                    state_next = ST_EVAL_MUL;
            end
            ST_PUSH:
            begin
                ld_x = sat_coord(ptx_reg);
                ld_y = sat_coord(pty_reg);
                ld_src = root_src_reg[ridx] ? SRC_YEXT : SRC_XEXT;
                last_flag = ((3'(ridx) + 3'd1) == nroots_reg);
                if (out_free)
                begin
                    out_load = 1'b1;
                    state_next = last_flag ? ST_IDLE : ST_EMIT;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
        if (adv_axis)
            state_next = axis_reg ? ST_EMIT : ST_COEF;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= 1'b0;
            nroots_reg    <= 3'd0;
            emit_reg      <= 3'd0;
            step_reg      <= 3'd0;
            ev_axis_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
            begin
                axis_reg   <= 1'b0;
                nroots_reg <= 3'd0;
                emit_reg   <= 3'd0;
            end
            if (adv_axis)
                axis_reg <= 1'b1;
            if (store_root)
                nroots_reg <= nroots_reg + 3'd1;
            if (out_load)
                emit_reg <= emit_reg + 3'd1;
            if (state_reg == ST_EMIT && emit_reg >= 3'd2)
            begin
                step_reg    <= 3'd0;
                ev_axis_reg <= 1'b0;
            end
            if (state_reg == ST_EVAL_ADD)
            begin
                if (step_reg == final_step)
                begin
                    step_reg    <= 3'd0;
                    ev_axis_reg <= 1'b1;
                end
                else
                    step_reg <= step_after;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_item;
        if (state_reg == ST_COEF)
        begin
            a_reg <= cf.a[COEF_W-1] ? -$signed({1'b0, na[NORM_BITS-1:0]})
                                    : $signed({1'b0, na[NORM_BITS-1:0]});
            b_reg <= cf.b[COEF_W-1] ? -$signed({1'b0, nb[NORM_BITS-1:0]})
                                    : $signed({1'b0, nb[NORM_BITS-1:0]});
            c_reg <= cf.c[COEF_W-1] ? -$signed({1'b0, nc[NORM_BITS-1:0]})
                                    : $signed({1'b0, nc[NORM_BITS-1:0]});
        end
        if (state_reg == ST_MULT)
        begin
            bb_reg <= b_reg * b_reg;
            ac_reg <= a_reg * c_reg;
        end
        if (state_reg == ST_SQRT && sqrt_done)
            q2_reg <= q2_next;
        if (store_root)
        begin
            root_t_reg[nroots_reg[1:0]]   <= div_q;
            root_src_reg[nroots_reg[1:0]] <= axis_reg;
        end
        if (state_reg == ST_EVAL_MUL)
        begin
            prod_reg   <= (lb - la) * $signed({1'b0, root_t_reg[ridx]});
            lerp_a_reg <= la;
        end
        if (state_reg == ST_EVAL_ADD)
        begin
            w_reg[step_reg] <= lerp_res;
            if (step_reg == final_step)
            begin
                if (ev_axis_reg)
                    pty_reg <= lerp_res;
                else
                    ptx_reg <= lerp_res;
            end
        end
        if (out_load)
        begin
            out_x_reg    <= ld_x;
            out_y_reg    <= ld_y;
            out_src_reg  <= ld_src;
            out_last_reg <= last_flag;
        end
    end

    always_comb
    begin
        m_axis_tvalid = out_valid_reg;
        m_axis_tdata  = {out_y_reg, out_x_reg};
        m_axis_tuser  = out_src_reg;
        m_axis_tlast  = out_last_reg;
    end

endmodule
`default_nettype wire

FILE: src/bezier_extrema_points.sv
`default_nettype none
// Extreme points of path segments. Each transfer on the input stream carries one line,
// quadratic or cubic segment in signed Q16.16; the block answers with its start point,
// its end point and then every curve point where dx/dt (first) or dy/dt (then) is zero
// for t in [0,1], with tlast on the final point of the segment. A curve runs, per axis,
// up to an iterative square root and two iterative divisions, then evaluates the curve
// at each root in the single shared lerp multiplier and hands the point out. A two-entry
// queue behind the input lets the next segments be taken while one is solved, and an
// output register holds a finished point while the solver keeps working.
module bezier_extrema_points
    import bep_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [THR_W-1:0]      cfg_wdata,      // zero_threshold
    // start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y (lowest first)
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic [1:0]            s_axis_tuser,   // curve_kind
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // point_x, point_y (lowest first)
    output logic [1:0]                 m_axis_tuser,   // point_source
    output logic                       m_axis_tlast,   // last_point
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready
);

    // Leading and middle coefficient magnitudes below this count as zero; it resets to one raw unit.
    logic [THR_W-1:0] thr_reg;

    logic  q_full;
    logic  q_push;
    item_t q_in;
    logic  q_pop;
    item_t q_head;
    logic  q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_W'(1);
        else if (cfg_we)
            thr_reg <= cfg_wdata;
    end

    // The front end sorts the segment kind and forms both derivative quadratics.
    bep_front u_front (
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (q_in)
    );

    bep_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .valid     (q_valid)
    );

    // The back end finds the roots of each axis and evaluates the curve at them.
    bep_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .threshold     (thr_reg),
        .q_valid       (q_valid),
        .q_item        (q_head),
        .q_pop         (q_pop),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

`ifndef SYNTHESIS
    // A segment always has its end point after the start, so a start never closes it.
    a_start_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == SRC_START |-> !m_axis_tlast)
        else $error("start point marked as last");

    // The transfer right after a start point carries the end point.
    a_end_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tuser == SRC_START
        |=> !(m_axis_tvalid && m_axis_tready) || m_axis_tuser == SRC_END)
        else $error("end point does not follow start point");

    // After the last point of a segment the next transfer opens a new segment.
    a_new_segment: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast
        |=> !m_axis_tvalid || m_axis_tuser == SRC_START)
        else $error("segment does not open with its start point");
`endif

endmodule
`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps
`default_nettype none

module testbench
    import bep_pkg::*;
();

    // Segment kind one has no constant in the package.
    localparam logic [1:0] KIND_QUAD = 2'd1;
    localparam logic [31:0] ONE = 32'h0001_0000;
    localparam logic [31:0] CMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] CMIN = 32'h8000_0000;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        src_t               src;
        logic               last;
    } point_t;

    typedef struct {
        logic [1:0]       kind;
        logic [7:0][31:0] c;    // start_x, start_y, ctrl1_x, ... end_y
        bit               typed;
    } seg_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [THR_W-1:0]      cfg_wdata;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;

    bezier_extrema_points dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    // Points still owed by the block, oldest first.
    point_t pending_points[$];
    // Directed stimulus table.
    seg_row_t seg_rows[$];
    // Local copy of the zero threshold register.
    longint unsigned zero_thr;
    int  errors;
    bit  steady;        // when set, neither side inserts random idle cycles
    int  received;

    always #10 clk = ~clk;

    task automatic queue_point(point_t p);
        pending_points.insert(pending_points.size(), p);
    endtask

    task automatic add_row(logic [1:0] kind, logic [7:0][31:0] c, bit typed);
        seg_row_t r;
        r.kind = kind;
        r.c = c;
        r.typed = typed;
        seg_rows.insert(seg_rows.size(), r);
    endtask

    // ---------------------------------------------------------------
    // Predictor: integer derivative solver plus de Casteljau evaluation.
    // ---------------------------------------------------------------
    function automatic longint unsigned magn(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Keeps n/d as an unsigned Q1.30 parameter when it lies in [0,1].
    function automatic bit param_in_unit(longint n, longint d, output longint unsigned t);
        longint unsigned un;
        longint unsigned ud;
        longint unsigned q;
        longint unsigned r;
        t = 0;
        if (d == 0)
            return 0;
        if (n != 0 && ((n < 0) != (d < 0)))
            return 0;
        un = magn(n);
        ud = magn(d);
        if (un > ud)
            return 0;
        q = 0;
        r = un;
        if (r >= ud)
        begin
            q = 1;
            r -= ud;
        end
        for (int i = 0; i < TFRAC; i++)
        begin
            r <<= 1;
            q <<= 1;
            if (r >= ud)
            begin
                r -= ud;
                q |= 1;
            end
        end
        t = q;
        return 1;
    endfunction

    function automatic longint blend(longint a, longint b, longint unsigned t);
        longint m;
        m = (b - a) * longint'(t) + (64'sd1 <<< (TFRAC - 1));
        return a + (m >>> TFRAC);
    endfunction

    function automatic longint curve_at(bit cubic, longint p[4], longint unsigned t);
        longint a;
        longint b;
        longint c;
        longint d;
        longint e;
        if (cubic)
        begin
            a = blend(p[0], p[1], t);
            b = blend(p[1], p[2], t);
            c = blend(p[2], p[3], t);
            d = blend(a, b, t);
            e = blend(b, c, t);
            return blend(d, e, t);
        end
        a = blend(p[0], p[1], t);
        b = blend(p[1], p[3], t);
        return blend(a, b, t);
    endfunction

    // Parameters where the derivative of one axis vanishes, from scaled points.
    function automatic int stationary_params(longint s[4], output longint unsigned t[2]);
        longint cA;
        longint cB;
        longint cC;
        longint a;
        longint b;
        longint c;
        longint disc;
        longint q2;
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned mc;
        int sh;
        int n;
        cA = -s[0] + 3 * s[1] - 3 * s[2] + s[3];
        cB = 2 * (s[0] - 2 * s[1] + s[2]);
        cC = s[1] - s[0];
        ma = magn(cA);
        mb = magn(cB);
        mc = magn(cC);
        n = 0;
        t[0] = 0;
        t[1] = 0;
        if (ma < zero_thr)
        begin
            if (mb < zero_thr)
                return 0;
            return param_in_unit(-cC, cB, t[0]) ? 1 : 0;
        end
        sh = 0;
        while (((ma | mb | mc) >> sh) >= (64'd1 << 30))
            sh++;
        a = longint'(ma >> sh);
        b = longint'(mb >> sh);
        c = longint'(mc >> sh);
        if (cA < 0)
            a = -a;
        if (cB < 0)
            b = -b;
        if (cC < 0)
            c = -c;
        disc = b * b - 4 * a * c;
        if (disc < 0)
            return 0;
        q2 = longint'(int_sqrt(disc));
        q2 = (b < 0) ? q2 - b : -(b + q2);
        if (param_in_unit(q2, 2 * a, t[n]))
            n++;
        if (param_in_unit(2 * c, q2, t[n]))
            n++;
        return n;
    endfunction

    task automatic push_point(longint x, longint y, src_t src);
        point_t p;
        p.x = 32'(sat32(x));
        p.y = 32'(sat32(y));
        p.src = src;
        p.last = 1'b0;
        queue_point(p);
    endtask

    task automatic predict_extrema(logic [1:0] kind, logic [7:0][31:0] c);
        longint px[4];
        longint py[4];
        longint s[4];
        longint p[4];
        longint unsigned t[2];
        int nr;
        bit cubic;
        for (int i = 0; i < 4; i++)
        begin
            px[i] = longint'($signed(c[2 * i]));
            py[i] = longint'($signed(c[2 * i + 1]));
        end
        push_point(px[0], py[0], SRC_START);
        push_point(px[3], py[3], SRC_END);
        if (kind != KIND_LINE)
        begin
            cubic = kind[1];
            for (int ax = 0; ax < 2; ax++)
            begin
                for (int i = 0; i < 4; i++)
                    p[i] = (ax == 0) ? px[i] : py[i];
                if (cubic)
                begin
                    for (int i = 0; i < 4; i++)
                        s[i] = 3 * p[i];
                end
                else
                begin
                    s[0] = 3 * p[0];
                    s[1] = p[0] + 2 * p[1];
                    s[2] = 2 * p[1] + p[3];
                    s[3] = 3 * p[3];
                end
                nr = stationary_params(s, t);
                for (int i = 0; i < nr; i++)
                    push_point(curve_at(cubic, px, t[i]), curve_at(cubic, py, t[i]),
                               ax == 0 ? SRC_XEXT : SRC_YEXT);
            end
        end
        pending_points[$].last = 1'b1;
    endtask

    // ---------------------------------------------------------------
    // Input side. The transfer completes at the edge where tready is seen
    // high; the expectation is built right then, so it always precedes
    // the points the block produces for that segment.
    // ---------------------------------------------------------------
    task automatic send_segment(logic [1:0] kind, logic [7:0][31:0] c, bit typed);
        point_t p;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= c;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (typed)
        begin
            // A line answers with exactly its two end points.
            p.x = c[0];
            p.y = c[1];
            p.src = SRC_START;
            p.last = 1'b0;
            queue_point(p);
            p.x = c[6];
            p.y = c[7];
            p.src = SRC_END;
            p.last = 1'b1;
            queue_point(p);
        end
        else
            predict_extrema(kind, c);
        // Idle between transfers at random; most gaps are short.
        if (!steady && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {8{$urandom}};
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(15, 60)) @(posedge clk);
            else
                repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic drain_and_configure(logic [15:0] thr);
        // Withdraw the offer first so the last segment is not taken twice.
        s_axis_tvalid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        // Let the output register settle before the register changes.
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= thr;
        @(posedge clk);
        cfg_we    <= 1'b0;
        zero_thr = thr;
    endtask

    // Random segment: mostly moderate coordinates that keep the solver busy
    // with genuine extrema, some full-range words for saturation and overflow.
    function automatic logic [7:0][31:0] random_coords();
        logic [7:0][31:0] c;
        int style;
        style = $urandom_range(0, 9);
        for (int i = 0; i < 8; i++)
        begin
            if (style < 6)
                c[i] = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
            else if (style < 8)
                c[i] = $urandom;
            else
                c[i] = $urandom_range(0, 1) ? CMAX - $urandom_range(0, 255)
                                            : CMIN + $urandom_range(0, 255);
        end
        // Occasionally repeat a point so coefficients collapse toward zero.
        if ($urandom_range(0, 7) == 0)
        begin
            c[2] = c[0];
            c[3] = c[1];
        end
        return c;
    endfunction

    // ---------------------------------------------------------------
    // Output side: checks every transfer and drives tready. After a few
    // hundred points it holds off for a long stretch so the input queue
    // fills and the block stalls its input.
    // ---------------------------------------------------------------
    initial
    begin : result_side
        point_t exp_pt;
        int stall_left;
        bit held;
        stall_left = 0;
        held = 0;
        received = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                received++;
                if (pending_points.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected point x=%h y=%h source=%0d last=%b", $time,
                             m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser,
                             m_axis_tlast);
                end
                else
                begin
                    exp_pt = pending_points.pop_front();
                    if (m_axis_tdata[31:0] !== exp_pt.x)
                    begin
                        errors++;
                        $display("%0t: point_x expected %h actual %h", $time, exp_pt.x,
                                 m_axis_tdata[31:0]);
                    end
                    if (m_axis_tdata[63:32] !== exp_pt.y)
                    begin
                        errors++;
                        $display("%0t: point_y expected %h actual %h", $time, exp_pt.y,
                                 m_axis_tdata[63:32]);
                    end
                    if (m_axis_tuser !== exp_pt.src)
                    begin
                        errors++;
                        $display("%0t: point_source expected %0d actual %0d", $time,
                                 exp_pt.src, m_axis_tuser);
                    end
                    if (m_axis_tlast !== exp_pt.last)
                    begin
                        errors++;
                        $display("%0t: last_point expected %b actual %b", $time,
                                 exp_pt.last, m_axis_tlast);
                    end
                end
            end
            if (!held && received >= 300)
            begin
                held = 1;
                stall_left = 600;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 5) == 0)
            begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                         : $urandom_range(0, 2);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin : limit
        #20ms;
        $display("bezier_extrema_points test failed");
        $finish;
    end

    initial
    begin : stimulus
        seg_row_t row;
        logic [15:0] thr_steps[5];
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_axis_tdata = '0;
        s_axis_tuser = KIND_LINE;
        s_axis_tvalid = 1'b0;
        errors = 0;
        steady = 0;
        zero_thr = 1;

        // Directed segments. Lines carry their expectation inline.
        add_row(KIND_LINE, '0, 1);
        add_row(KIND_LINE, {CMAX, CMIN, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX}, 1);
        add_row(KIND_LINE, {CMIN, CMAX, 32'hFFFF_FFFF, 32'h5555_5555,
                            32'hAAAA_AAAA, 32'h1234_5678, CMAX, CMIN}, 1);
        // Parabola in x with its apex a third of the way along.
        add_row(KIND_QUAD, {32'h0, 32'h0, 32'h0, 32'h0,
                            32'h0, 2 * ONE, 32'h0, ONE}, 0);
        // Parabola in y, second control point ignored.
        add_row(KIND_QUAD, {ONE, 3 * ONE, 32'h1234_5678, CMAX,
                            0 - ONE, 2 * ONE, 32'h0, 32'h0}, 0);
        // S-shaped cubic with two x extrema.
        add_row(KIND_CUBIC, {3 * ONE, 2 * ONE, 2 * ONE, 0 - ONE,
                             ONE, 3 * ONE, 32'h0, 32'h0}, 0);
        // The same under the alternate cubic code.
        add_row(KIND_CUBIC_ALT, {3 * ONE, 2 * ONE, 2 * ONE, 0 - ONE,
                                 ONE, 3 * ONE, 32'h0, 32'h0}, 0);
        // All four points equal: every coefficient vanishes.
        add_row(KIND_CUBIC, {8{32'h0003_8000}}, 0);
        // Evenly spaced collinear points: constant derivative, no root.
        add_row(KIND_CUBIC, {3 * ONE, 3 * ONE, 2 * ONE, 2 * ONE,
                             ONE, ONE, 32'h0, 32'h0}, 0);
        // Cubic whose leading y term cancels, leaving a single root.
        add_row(KIND_CUBIC, {32'h0, ONE, 2 * ONE, 32'h0,
                             2 * ONE, ONE, 32'h0, 32'h0}, 0);
        // Monotone y with negative discriminant.
        add_row(KIND_CUBIC, {4 * ONE, 32'h0, 2 * ONE, 32'h0,
                             ONE, ONE, 32'h0, 32'h0}, 0);
        // Alternating extremes: large coefficients and saturated points.
        add_row(KIND_CUBIC, {CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN}, 0);
        add_row(KIND_CUBIC, {8{CMAX}}, 0);
        add_row(KIND_QUAD, {CMAX, CMIN, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN}, 0);
        // Control point on the start point: root at t equal to zero.
        add_row(KIND_QUAD, {2 * ONE, ONE, 32'h0, 32'h0,
                            32'h0, 32'h0, 32'h0, 32'h0}, 0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pass at the reset threshold, then again with zero.
        foreach (seg_rows[i])
            send_segment(seg_rows[i].kind, seg_rows[i].c, seg_rows[i].typed);
        drain_and_configure(16'd0);
        foreach (seg_rows[i])
            send_segment(seg_rows[i].kind, seg_rows[i].c, 0);

        // Random phases across threshold settings, extremes included.
        thr_steps[0] = 16'd1;
        thr_steps[1] = 16'hFFFF;
        thr_steps[2] = 16'($urandom_range(2, 16'hFFFE));
        thr_steps[3] = 16'd0;
        thr_steps[4] = 16'd64;
        for (int ph = 0; ph < 5; ph++)
        begin
            drain_and_configure(thr_steps[ph]);
            steady = (ph == 2);
            repeat (66)
            begin
                row.kind = 2'($urandom_range(0, 3));
                row.c = random_coords();
                send_segment(row.kind, row.c, 0);
            end
        end
        steady = 0;
        s_axis_tvalid <= 1'b0;

        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("bezier_extrema_points test passed");
        else
            $display("bezier_extrema_points test failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
src/bep_pkg.sv
src/bep_front.sv
src/bep_queue.sv
src/bep_isqrt.sv
src/bep_div.sv
src/bep_back.sv
src/bezier_extrema_points.sv
sim/testbench.sv
